// ----- src/tdpm_pkg.sv -----
// ---------------------------------------------------------------------------
// tdpm_pkg
// Shared types and constants of the demand paging MMU with its TLB.
// ---------------------------------------------------------------------------
package tdpm_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int TLB_DEPTH  = 16;
   localparam int FRAME_W    = 6;
   localparam int TLB_W      = 4;
   localparam int COUNT_W    = 7;
   localparam int TLB_CNT_W  = 5;
   localparam int COST_W     = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_OFFSET_BITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TLB_ENTRIES      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_POLICY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TLB_COST         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_COST         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_READ_COST   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_WRITE_COST  = 3'd7;

   localparam logic [1:0] OUT_TLB_HIT  = 2'd0;
   localparam logic [1:0] OUT_PT_HIT   = 2'd1;
   localparam logic [1:0] OUT_FILL     = 2'd2;
   localparam logic [1:0] OUT_REPLACE  = 2'd3;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   typedef struct packed {
      logic [4:0]  page_offset_bits;
      logic [6:0]  frame_count;
      logic [4:0]  tlb_entries;
      logic        replace_policy;
      logic [15:0] tlb_cost;
      logic [15:0] ram_cost;
      logic [15:0] disk_read_cost;
      logic [15:0] disk_write_cost;
   } cfg_type;

   typedef struct packed {
      logic        wr;
      logic [31:0] page;
   } item_type;

endpackage

// ----- src/tdpm_req_if.sv -----
// ---------------------------------------------------------------------------
// tdpm_req_if
// Request channel: one memory access per request.
// ---------------------------------------------------------------------------
interface tdpm_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] virtual_address;

   modport source (output valid, output req_type, output virtual_address, input ready);
   modport sink (input valid, input req_type, input virtual_address, output ready);
endinterface

// ----- src/tdpm_rsp_if.sv -----
// ---------------------------------------------------------------------------
// tdpm_rsp_if
// Result channel: one translation result per request.
// ---------------------------------------------------------------------------
interface tdpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  outcome;
   logic [5:0]  frame_number;
   logic [31:0] victim_page;
   logic        victim_was_dirty;
   logic [18:0] access_cost;

   modport source (output valid, output outcome, output frame_number, output victim_page,
                   output victim_was_dirty, output access_cost, input ready);
   modport sink (input valid, input outcome, input frame_number, input victim_page,
                 input victim_was_dirty, input access_cost, output ready);
endinterface

// ----- src/tdpm_front.sv -----
// ---------------------------------------------------------------------------
// tdpm_front
// Accepts requests, extracts the page number and queues them in two entries.
// ---------------------------------------------------------------------------
module tdpm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [4:0]           page_offset_bits,
   tdpm_req_if.sink             req,
   output logic                 q_valid,
   input  logic                 q_ready,
   output tdpm_pkg::item_type   q_item
);

   tdpm_pkg::item_type queue_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req.ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = queue_ff[rptr_ff];
   assign push      = req.valid && req.ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wptr_ff].wr   <= req.req_type;
         queue_ff[wptr_ff].page <= req.virtual_address >> page_offset_bits;
      end
   end

endmodule

// ----- src/tdpm_back.sv -----
// ---------------------------------------------------------------------------
// tdpm_back
// Carries out one translation: TLB search, frame table scan, replacement,
// LRU rank update and result register.
// ---------------------------------------------------------------------------
module tdpm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tdpm_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  tdpm_pkg::item_type   q_item,
   tdpm_rsp_if.source           rsp
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TLB    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_UPD    = 3'd5;
   localparam logic [2:0] S_TOUCH  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   localparam int FW = tdpm_pkg::FRAME_W;
   localparam int CW = tdpm_pkg::COUNT_W;

   logic [2:0]    state_ff, state_in;
   logic          wr_ff, wr_in;
   logic [31:0]   page_ff, page_in;
   logic [1:0]    kind_ff, kind_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic [FW-1:0] best_ff, best_in;
   logic [FW-1:0] lru_ff, lru_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          vld_ff, vld_in;
   logic [FW-1:0] chk_ff, chk_in;
   logic [FW-1:0] old_rank_ff, old_rank_in;
   logic [CW-1:0] filled_ff, filled_in;
   logic [FW-1:0] fifo_ff, fifo_in;
   logic [tdpm_pkg::TLB_W-1:0] slot_ff, slot_in;
   logic [tdpm_pkg::TLB_DEPTH-1:0] tlb_valid_ff, tlb_valid_in;
   logic [31:0]   tlb_page_ff  [tdpm_pkg::TLB_DEPTH];
   logic [FW-1:0] tlb_frame_ff [tdpm_pkg::TLB_DEPTH];
   logic          tlb_we;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic [FW-1:0] out_frame_ff, out_frame_in;
   logic [31:0]   out_vpage_ff, out_vpage_in;
   logic          out_vdirty_ff, out_vdirty_in;
   logic [18:0]   out_cost_ff, out_cost_in;
   logic [1:0]    res_kind_ff, res_kind_in;
   logic [31:0]   res_vpage_ff, res_vpage_in;
   logic          res_vdirty_ff, res_vdirty_in;
   logic [18:0]   res_cost_ff, res_cost_in;

   logic [18:0]   cost_hit_ff, cost_pt_ff, cost_fault_ff;

   logic [32:0]   page_mem [tdpm_pkg::MAX_FRAMES];
   logic [FW-1:0] rank_mem [tdpm_pkg::MAX_FRAMES];
   logic [32:0]   page_rd_ff;
   logic [FW-1:0] rank_rd_ff;
   logic [FW-1:0] rd_addr;
   logic          page_we;
   logic [32:0]   page_wdata;
   logic          rank_we;
   logic [FW-1:0] rank_wdata;

   logic          tlb_hit;
   logic [FW-1:0] tlb_hit_frame;
   logic [tdpm_pkg::TLB_DEPTH-1:0] inval;
   logic [CW-1:0] eff_frames;
   logic [tdpm_pkg::TLB_CNT_W-1:0] eff_tlb;
   logic [CW-1:0] last_idx;
   logic [CW-1:0] fifo_pick;
   logic [CW-1:0] fifo_next;
   logic [tdpm_pkg::TLB_CNT_W-1:0] slot_pick;
   logic [tdpm_pkg::TLB_CNT_W-1:0] slot_next;

   always_comb begin
      tlb_hit       = 1'b0;
      tlb_hit_frame = '0;
      for (int i = tdpm_pkg::TLB_DEPTH - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && tlb_page_ff[i] == page_ff) begin
            tlb_hit       = 1'b1;
            tlb_hit_frame = tlb_frame_ff[i];
         end
      end
      for (int i = 0; i < tdpm_pkg::TLB_DEPTH; i++) begin
         inval[i] = tlb_valid_ff[i] && (tlb_page_ff[i] == page_rd_ff[31:0]);
      end
   end

   always_comb begin
      if (cfg.frame_count == '0) begin
         eff_frames = CW'(1);
      end else if (cfg.frame_count > CW'(tdpm_pkg::MAX_FRAMES)) begin
         eff_frames = CW'(tdpm_pkg::MAX_FRAMES);
      end else begin
         eff_frames = cfg.frame_count;
      end
      if (cfg.tlb_entries == '0) begin
         eff_tlb = tdpm_pkg::TLB_CNT_W'(1);
      end else if (cfg.tlb_entries > tdpm_pkg::TLB_CNT_W'(tdpm_pkg::TLB_DEPTH)) begin
         eff_tlb = tdpm_pkg::TLB_CNT_W'(tdpm_pkg::TLB_DEPTH);
      end else begin
         eff_tlb = cfg.tlb_entries;
      end
      last_idx  = filled_ff - CW'(1);
      fifo_pick = ({1'b0, fifo_ff} < eff_frames) ? {1'b0, fifo_ff} : '0;
      fifo_next = ((fifo_pick + CW'(1)) >= eff_frames) ? '0 : fifo_pick + CW'(1);
      slot_pick = ({1'b0, slot_ff} < eff_tlb) ? {1'b0, slot_ff} : '0;
      slot_next = ((slot_pick + 5'd1) >= eff_tlb) ? '0 : slot_pick + 5'd1;
   end

   assign q_ready              = (state_ff == S_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.outcome          = out_kind_ff;
   assign rsp.frame_number     = out_frame_ff;
   assign rsp.victim_page      = out_vpage_ff;
   assign rsp.victim_was_dirty = out_vdirty_ff;
   assign rsp.access_cost      = out_cost_ff;

   always_comb begin
      state_in      = state_ff;
      wr_in         = wr_ff;
      page_in       = page_ff;
      kind_in       = kind_ff;
      frame_in      = frame_ff;
      best_in       = best_ff;
      lru_in        = lru_ff;
      issue_in      = issue_ff;
      vld_in        = 1'b0;
      chk_in        = chk_ff;
      old_rank_in   = old_rank_ff;
      filled_in     = filled_ff;
      fifo_in       = fifo_ff;
      slot_in       = slot_ff;
      tlb_valid_in  = tlb_valid_ff;
      tlb_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      out_kind_in   = out_kind_ff;
      out_frame_in  = out_frame_ff;
      out_vpage_in  = out_vpage_ff;
      out_vdirty_in = out_vdirty_ff;
      out_cost_in   = out_cost_ff;
      res_kind_in   = res_kind_ff;
      res_vpage_in  = res_vpage_ff;
      res_vdirty_in = res_vdirty_ff;
      res_cost_in   = res_cost_ff;
      rd_addr       = frame_ff;
      page_we       = 1'b0;
      page_wdata    = {wr_ff, page_ff};
      rank_we       = 1'b0;
      rank_wdata    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               wr_in    = q_item.wr;
               page_in  = q_item.page;
               state_in = S_TLB;
            end
         end
         S_TLB: begin
            best_in  = '0;
            lru_in   = '0;
            issue_in = '0;
            if (tlb_hit) begin
               kind_in  = tdpm_pkg::OUT_TLB_HIT;
               frame_in = tlb_hit_frame;
               state_in = S_READ;
            end else if (filled_ff == '0) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff < filled_ff) begin
               rd_addr  = issue_ff[FW-1:0];
               issue_in = issue_ff + CW'(1);
               vld_in   = 1'b1;
               chk_in   = issue_ff[FW-1:0];
            end
            if (vld_ff) begin
               if (page_rd_ff[31:0] == page_ff) begin
                  kind_in  = tdpm_pkg::OUT_PT_HIT;
                  frame_in = chk_ff;
                  vld_in   = 1'b0;
                  state_in = S_READ;
               end else begin
                  if (rank_rd_ff > best_ff) begin
                     best_in = rank_rd_ff;
                     lru_in  = chk_ff;
                  end
                  if ({1'b0, chk_ff} == last_idx) begin
                     vld_in   = 1'b0;
                     state_in = S_DECIDE;
                  end
               end
            end
         end
         S_DECIDE: begin
            if (filled_ff < eff_frames) begin
               kind_in  = tdpm_pkg::OUT_FILL;
               frame_in = filled_ff[FW-1:0];
            end else begin
               kind_in = tdpm_pkg::OUT_REPLACE;
               if (cfg.replace_policy == tdpm_pkg::POLICY_LRU) begin
                  frame_in = lru_ff;
               end else begin
                  frame_in = fifo_pick[FW-1:0];
                  fifo_in  = fifo_next[FW-1:0];
               end
            end
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            page_we       = 1'b1;
            res_kind_in   = kind_ff;
            res_vpage_in  = '0;
            res_vdirty_in = 1'b0;
            old_rank_in   = rank_rd_ff;
            issue_in      = '0;
            unique case (kind_ff)
               tdpm_pkg::OUT_TLB_HIT: begin
                  page_wdata  = {page_rd_ff[32] | wr_ff, page_rd_ff[31:0]};
                  res_cost_in = cost_hit_ff;
               end
               tdpm_pkg::OUT_PT_HIT: begin
                  page_wdata  = {page_rd_ff[32] | wr_ff, page_rd_ff[31:0]};
                  res_cost_in = cost_pt_ff;
               end
               tdpm_pkg::OUT_FILL: begin
                  filled_in   = filled_ff + CW'(1);
                  old_rank_in = filled_ff[FW-1:0];
                  res_cost_in = cost_fault_ff;
               end
               tdpm_pkg::OUT_REPLACE: begin
                  res_vpage_in  = page_rd_ff[31:0];
                  res_vdirty_in = page_rd_ff[32];
                  res_cost_in   = cost_fault_ff
                                + (page_rd_ff[32] ? 19'(cfg.disk_write_cost) : 19'd0);
                  tlb_valid_in  = tlb_valid_ff & ~inval;
               end
               default: begin
                  res_cost_in = cost_hit_ff;
               end
            endcase
            if (kind_ff != tdpm_pkg::OUT_TLB_HIT) begin
               tlb_we                                    = 1'b1;
               tlb_valid_in[slot_pick[tdpm_pkg::TLB_W-1:0]] = 1'b1;
               slot_in                                   = slot_next[tdpm_pkg::TLB_W-1:0];
            end
            state_in = S_TOUCH;
         end
         S_TOUCH: begin
            if (issue_ff < filled_ff) begin
               rd_addr  = issue_ff[FW-1:0];
               issue_in = issue_ff + CW'(1);
               vld_in   = 1'b1;
               chk_in   = issue_ff[FW-1:0];
            end
            if (vld_ff) begin
               rank_we = 1'b1;
               if (chk_ff == frame_ff) begin
                  rank_wdata = '0;
               end else if (rank_rd_ff < old_rank_ff) begin
                  rank_wdata = rank_rd_ff + FW'(1);
               end else begin
                  rank_wdata = rank_rd_ff;
               end
               if ({1'b0, chk_ff} == last_idx) begin
                  vld_in   = 1'b0;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               out_kind_in   = res_kind_ff;
               out_frame_in  = frame_ff;
               out_vpage_in  = res_vpage_ff;
               out_vdirty_in = res_vdirty_ff;
               out_cost_in   = res_cost_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= 1'b0;
         filled_ff    <= '0;
         fifo_ff      <= '0;
         slot_ff      <= '0;
         tlb_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         filled_ff    <= filled_in;
         fifo_ff      <= fifo_in;
         slot_ff      <= slot_in;
         tlb_valid_ff <= tlb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff         <= wr_in;
      page_ff       <= page_in;
      kind_ff       <= kind_in;
      frame_ff      <= frame_in;
      best_ff       <= best_in;
      lru_ff        <= lru_in;
      issue_ff      <= issue_in;
      chk_ff        <= chk_in;
      old_rank_ff   <= old_rank_in;
      out_kind_ff   <= out_kind_in;
      out_frame_ff  <= out_frame_in;
      out_vpage_ff  <= out_vpage_in;
      out_vdirty_ff <= out_vdirty_in;
      out_cost_ff   <= out_cost_in;
      res_kind_ff   <= res_kind_in;
      res_vpage_ff  <= res_vpage_in;
      res_vdirty_ff <= res_vdirty_in;
      res_cost_ff   <= res_cost_in;
      cost_hit_ff   <= 19'(cfg.tlb_cost) + 19'(cfg.ram_cost);
      cost_pt_ff    <= 19'(cfg.tlb_cost) + 19'(cfg.ram_cost) + 19'(cfg.ram_cost);
      cost_fault_ff <= cost_pt_ff + 19'(cfg.disk_read_cost);
      if (tlb_we) begin
         tlb_page_ff[slot_pick[tdpm_pkg::TLB_W-1:0]]  <= page_ff;
         tlb_frame_ff[slot_pick[tdpm_pkg::TLB_W-1:0]] <= frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (page_we) begin
         page_mem[frame_ff] <= page_wdata;
      end
      page_rd_ff <= page_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[chk_ff] <= rank_wdata;
      end
      rank_rd_ff <= rank_mem[rd_addr];
   end

endmodule

// ----- src/tlb_demand_paging_mmu.sv -----
// ---------------------------------------------------------------------------
// tlb_demand_paging_mmu
// Demand paging MMU with a FIFO-replaced TLB and FIFO or LRU frame eviction.
// ---------------------------------------------------------------------------
// Each request on the req channel carries an access kind and a 32-bit virtual
// address; each produces exactly one result on the rsp channel, in order,
// giving the outcome, the serving frame, any evicted page and its dirtiness,
// and the access cost. The user must write registers through the csr port
// only while the block is idle; the block itself does not enforce this.
// The front end queues up to two requests. The back end handles one request
// at a time: it searches the TLB, and the LRU rank update then visits each
// filled frame. A TLB miss adds a scan of the frame table at one frame per
// cycle before the serving frame is chosen.
// After reset the TLB is empty, no frame is filled and the registers hold
// their documented defaults. A stalled rsp channel holds the finished result;
// the back end then waits and the queue fills before req.ready falls.
// ---------------------------------------------------------------------------
module tlb_demand_paging_mmu (
   input  logic                                clock,
   input  logic                                reset,
   tdpm_req_if.sink                            req,
   tdpm_rsp_if.source                          rsp,
   input  logic                                csr_write_enable,
   input  logic [tdpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tdpm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   tdpm_pkg::cfg_type  cfg_ff, cfg_in;
   logic               q_valid;
   logic               q_ready;
   tdpm_pkg::item_type q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tdpm_pkg::CSR_PAGE_OFFSET_BITS: cfg_in.page_offset_bits = csr_write_data[4:0];
            tdpm_pkg::CSR_FRAME_COUNT:      cfg_in.frame_count      = csr_write_data[6:0];
            tdpm_pkg::CSR_TLB_ENTRIES:      cfg_in.tlb_entries      = csr_write_data[4:0];
            tdpm_pkg::CSR_REPLACE_POLICY:   cfg_in.replace_policy   = csr_write_data[0];
            tdpm_pkg::CSR_TLB_COST:         cfg_in.tlb_cost         = csr_write_data;
            tdpm_pkg::CSR_RAM_COST:         cfg_in.ram_cost         = csr_write_data;
            tdpm_pkg::CSR_DISK_READ_COST:   cfg_in.disk_read_cost   = csr_write_data;
            tdpm_pkg::CSR_DISK_WRITE_COST:  cfg_in.disk_write_cost  = csr_write_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_offset_bits <= 5'd12;
         cfg_ff.frame_count      <= 7'd64;
         cfg_ff.tlb_entries      <= 5'd16;
         cfg_ff.replace_policy   <= tdpm_pkg::POLICY_FIFO;
         cfg_ff.tlb_cost         <= '0;
         cfg_ff.ram_cost         <= '0;
         cfg_ff.disk_read_cost   <= '0;
         cfg_ff.disk_write_cost  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tdpm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .page_offset_bits (cfg_ff.page_offset_bits),
      .req              (req),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_item           (q_item)
   );

   tdpm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item),
      .rsp     (rsp)
   );

endmodule
